### hdl/okvt_pkg.sv
// Shared types and constants for the ordered key-value table.
// Used by okvt_seq, ordered_key_value_table_core and the testbench; depends on nothing.
`default_nettype none

package okvt_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_INS_UPD  = 3'd1,
    FN_UPDATE   = 3'd2,
    FN_ERASE    = 3'd3,
    FN_GET_KEY  = 3'd4,
    FN_GET_IDX  = 3'd5,
    FN_CONTAINS = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_IDX,
    ST_IDXRD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] fval;
    logic [KEY_W-1:0] fkey;
    logic             full;
    logic             ok;
  } res_t;

endpackage

`default_nettype wire

### hdl/ordered_key_value_table_core.sv
// Ordered key-value table with linear search: top level with the result register.
// Instantiates okvt_seq and okvt_mem; depends on okvt_pkg.
//
// Requests enter on the in_ channel: in_tuser carries the operation code and
// in_tdata the key, value and position. Each request yields exactly one
// result transaction on the out_ channel with the success and full flags,
// the key and value read and the entry count after the operation.
// Requests are handled one at a time; in_tready is high only while the
// sequencer is idle. A search reads one stored key per cycle through the
// single read port of the table memory and stops at the first match. An
// erase then moves every later entry down one place at one entry per
// cycle; search and shift together cover the table once. A read by
// position reads the table once, and not at all when the position lies
// past the end. The next request can be accepted as early as the cycle in
// which the result appears. Results go through an output register, so the
// next request is accepted while the previous result still waits; when the
// receiver stalls and that register is occupied, the sequencer holds its
// finished result and accepts nothing more. Reset empties the table at once
// (count to zero); the stored words themselves are not cleared.
`default_nettype none

module ordered_key_value_table_core #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // req_key[31:0], req_value[63:32], req_index[69:64]
  input  wire logic [2:0]  in_tuser,   // func[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [79:0] out_tdata   // success[0], table_full[1], found_key[33:2],
                                       // found_value[65:34], entry_count[72:66]
);

  import okvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;

  logic          res_valid;
  logic          out_free;
  res_t          res;
  res_t          out_data_r;
  logic          out_valid_r;
  logic          we_key;
  logic          we_val;
  logic [AW-1:0] waddr;
  logic [KW-1:0] wkey;
  logic [VW-1:0] wval;
  logic          re;
  logic [AW-1:0] raddr;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;

  assign out_free = !out_valid_r || out_tready;

  okvt_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW),
    .KW    (KW),
    .VW    (VW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_key    (in_tdata[31:0]),
    .in_val    (in_tdata[63:32]),
    .in_idx    (in_tdata[69:64]),
    .res_valid (res_valid),
    .res_ready (out_free),
    .res       (res),
    .we_key    (we_key),
    .we_val    (we_val),
    .waddr     (waddr),
    .wkey      (wkey),
    .wval      (wval),
    .re        (re),
    .raddr     (raddr),
    .rd_key    (rd_key),
    .rd_val    (rd_val)
  );

  okvt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .KW    (KW),
    .VW    (VW)
  ) u_mem (
    .clk    (clk),
    .we_key (we_key),
    .we_val (we_val),
    .waddr  (waddr),
    .wkey   (wkey),
    .wval   (wval),
    .re     (re),
    .raddr  (raddr),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_data_r.count, out_data_r.fval, out_data_r.fkey,
                       out_data_r.full, out_data_r.ok};

  // A refused insert never reports success.
  a_full_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.ok && out_data_r.full))
    else $error("result flags both success and full");

  // A failed request never reports a stored value.
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.ok) |-> (out_data_r.fval == '0))
    else $error("failed request reports a value");

  // The sequencer leaves the idle state on each accept, so an accept is never directly followed by another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in progress");

endmodule

`default_nettype wire

### hdl/okvt_mem.sv
// Key and value storage of the table: one write port and one registered read port.
// Parameterised by depth and widths; uses no package.
`default_nettype none

module okvt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int KW    = 32,
  parameter int VW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we_key,
  input  wire logic          we_val,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [KW-1:0] wkey,
  input  wire logic [VW-1:0] wval,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [KW-1:0] rd_key,
  output logic      [VW-1:0] rd_val
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_key) begin
      key_mem[waddr] <= wkey;
    end
    if (we_val) begin
      val_mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_key <= key_mem[raddr];
      rd_val <= val_mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/okvt_seq.sv
// Request sequencer: linear key search, insert, update, gap-closing erase and
// positional read, all through the one read port of okvt_mem. Depends on okvt_pkg.
`default_nettype none

module okvt_seq #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7,
  parameter int KW    = 32,
  parameter int VW    = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [2:0]                  in_func,
  input  wire logic [okvt_pkg::KEY_W-1:0]  in_key,
  input  wire logic [okvt_pkg::VAL_W-1:0]  in_val,
  input  wire logic [okvt_pkg::IDX_W-1:0]  in_idx,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output okvt_pkg::res_t                   res,
  output logic                             we_key,
  output logic                             we_val,
  output logic      [AW-1:0]               waddr,
  output logic      [KW-1:0]               wkey,
  output logic      [VW-1:0]               wval,
  output logic                             re,
  output logic      [AW-1:0]               raddr,
  input  wire logic [KW-1:0]               rd_key,
  input  wire logic [VW-1:0]               rd_val
);

  import okvt_pkg::*;

  localparam int IXW = (CW > IDX_W) ? CW : IDX_W;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] pend_idx_r, pend_idx_nxt;
  logic          hit_r, hit_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [VW-1:0] hit_val_r, hit_val_nxt;
  logic          ok_r, ok_nxt;
  logic          full_r, full_nxt;
  logic [KW-1:0] fkey_r, fkey_nxt;
  logic [VW-1:0] fval_r, fval_nxt;

  func_t              func_r;
  logic [KW-1:0]      key_r;
  logic [VW-1:0]      val_r;
  logic [IDX_W-1:0]   idx_r;

  logic               accept;
  logic               match;
  logic               more;
  logic [IXW-1:0]     idx_ext;

  assign accept  = in_valid && in_ready;
  assign match   = pend_r && (rd_key == key_r);
  assign more    = (ptr_r < count_r);
  assign idx_ext = IXW'(idx_r);

  // Request payload is held for the whole transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= func_t'(in_func);
      key_r  <= in_key[KW-1:0];
      val_r  <= in_val[VW-1:0];
      idx_r  <= in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    pos_r      <= pos_nxt;
    hit_val_r  <= hit_val_nxt;
    ok_r       <= ok_nxt;
    full_r     <= full_nxt;
    fkey_r     <= fkey_nxt;
    fval_r     <= fval_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ptr_nxt      = ptr_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    hit_nxt      = hit_r;
    pos_nxt      = pos_r;
    hit_val_nxt  = hit_val_r;
    ok_nxt       = ok_r;
    full_nxt     = full_r;
    fkey_nxt     = fkey_r;
    fval_nxt     = fval_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    we_key       = 1'b0;
    we_val       = 1'b0;
    waddr        = pos_r;
    wkey         = key_r;
    wval         = val_r;
    re           = 1'b0;
    raddr        = ptr_r[AW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ptr_nxt  = '0;
          pend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          ok_nxt   = 1'b0;
          full_nxt = 1'b0;
          fkey_nxt = '0;
          fval_nxt = '0;
          case (in_func) inside
            FN_INSERT, FN_INS_UPD, FN_UPDATE, FN_ERASE, FN_GET_KEY, FN_CONTAINS: begin
              state_nxt = ST_SCAN;
            end
            FN_GET_IDX: begin
              state_nxt = ST_IDX;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      // One entry is read per cycle; its key is compared in the next cycle.
      ST_SCAN: begin
        if (match) begin
          hit_nxt     = 1'b1;
          pos_nxt     = pend_idx_r[AW-1:0];
          hit_val_nxt = rd_val;
          pend_nxt    = 1'b0;
          state_nxt   = ST_DECIDE;
        end else begin
          re           = more;
          pend_nxt     = more;
          pend_idx_nxt = ptr_r;
          if (more) begin
            ptr_nxt = ptr_r + CW'(1);
          end
          if (!pend_r && !more) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_FIN;
        case (func_r) inside
          FN_INSERT, FN_INS_UPD: begin
            if (hit_r) begin
              if (func_r == FN_INS_UPD) begin
                we_val = 1'b1;
                ok_nxt = 1'b1;
              end
            end else if (count_r == CW'(DEPTH)) begin
              full_nxt = 1'b1;
            end else begin
              we_key    = 1'b1;
              we_val    = 1'b1;
              waddr     = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              ok_nxt    = 1'b1;
            end
          end
          FN_UPDATE: begin
            we_val = hit_r;
            ok_nxt = hit_r;
          end
          FN_ERASE: begin
            ok_nxt = hit_r;
            if (hit_r) begin
              ptr_nxt   = CW'(pos_r) + CW'(1);
              pend_nxt  = 1'b0;
              state_nxt = ST_SHIFT;
            end
          end
          FN_GET_KEY: begin
            fkey_nxt = key_r;
            ok_nxt   = hit_r;
            fval_nxt = hit_r ? hit_val_r : '0;
          end
          FN_CONTAINS: begin
            ok_nxt = hit_r;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      // Entries above the erased one move down by one: read j, write j-1.
      ST_SHIFT: begin
        re           = more;
        pend_nxt     = more;
        pend_idx_nxt = ptr_r;
        if (more) begin
          ptr_nxt = ptr_r + CW'(1);
        end
        if (pend_r) begin
          we_key = 1'b1;
          we_val = 1'b1;
          waddr  = AW'(pend_idx_r - CW'(1));
          wkey   = rd_key;
          wval   = rd_val;
        end
        if (!pend_r && !more) begin
          count_nxt = count_r - CW'(1);
          state_nxt = ST_FIN;
        end
      end

      ST_IDX: begin
        if (idx_ext < IXW'(count_r)) begin
          re        = 1'b1;
          raddr     = idx_ext[AW-1:0];
          state_nxt = ST_IDXRD;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_IDXRD: begin
        ok_nxt    = 1'b1;
        fkey_nxt  = rd_key;
        fval_nxt  = rd_val;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.ok    = ok_r;
    res.full  = full_r;
    res.fkey  = KEY_W'(fkey_r);
    res.fval  = VAL_W'(fval_r);
    res.count = CNT_W'(count_r);
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for ordered_key_value_table_core: an insertion-ordered table
// predictor in a small scoreboard class, stream drivers with random idling and back-pressure.
// Depends on okvt_pkg and the core's RTL only.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import okvt_pkg::*;

  localparam int          TABLE_DEPTH = 64;
  localparam logic [2:0]  FN_UNUSED   = 3'd7;
  localparam int          SEGMENTS    = 16;
  localparam int          SEG_ITEMS   = 100;
  localparam int          LONG_HOLD   = 300;
  localparam int          DRAIN_WAIT  = 160;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef enum {LOAD_FILL, LOAD_MIXED, LOAD_DRAIN} load_mix_t;

  // Holds a shadow copy of the table and the replies it still owes.
  class kv_table_scoreboard;
    logic [KEY_W-1:0] shadow_keys[TABLE_DEPTH];
    logic [VAL_W-1:0] shadow_values[TABLE_DEPTH];
    int unsigned      fill;
    res_t             pending_replies[$];
    int unsigned      mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function int unsigned position_of(logic [KEY_W-1:0] key);
      for (int i = 0; i < fill; i++) begin
        if (shadow_keys[i] == key) return i;
      end
      return TABLE_DEPTH;
    endfunction

    // Updates the shadow table for one request and returns the reply it should produce.
    function res_t apply_request(logic [2:0] op, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value, logic [IDX_W-1:0] index);
      res_t        reply;
      int unsigned pos;
      bit          present;
      reply = '0;
      pos = position_of(key);
      present = pos < TABLE_DEPTH;
      case (op) inside
        FN_INSERT, FN_INS_UPD: begin
          if (present) begin
            if (op == FN_INS_UPD) begin
              shadow_values[pos] = value;
              reply.ok = 1'b1;
            end
          end else if (fill >= TABLE_DEPTH) begin
            reply.full = 1'b1;
          end else begin
            shadow_keys[fill] = key;
            shadow_values[fill] = value;
            fill++;
            reply.ok = 1'b1;
          end
        end
        FN_UPDATE: begin
          if (present) begin
            shadow_values[pos] = value;
            reply.ok = 1'b1;
          end
        end
        FN_ERASE: begin
          if (present) begin
            // Later entries move down one place so that insertion order survives.
            for (int i = pos; i + 1 < fill; i++) begin
              shadow_keys[i] = shadow_keys[i + 1];
              shadow_values[i] = shadow_values[i + 1];
            end
            fill--;
            reply.ok = 1'b1;
          end
        end
        FN_GET_KEY: begin
          reply.fkey = key;
          if (present) begin
            reply.fval = shadow_values[pos];
            reply.ok = 1'b1;
          end
        end
        FN_GET_IDX: begin
          if (index < fill) begin
            reply.fkey = shadow_keys[index];
            reply.fval = shadow_values[index];
            reply.ok = 1'b1;
          end
        end
        FN_CONTAINS: begin
          reply.ok = present;
        end
        default: begin
        end
      endcase
      reply.count = fill[CNT_W-1:0];
      return reply;
    endfunction

    function void note_request(logic [2:0] op, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value, logic [IDX_W-1:0] index);
      pending_replies.push_back(apply_request(op, key, value, index));
    endfunction

    function void compare_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0h, got %0h", field, expected, actual);
        mismatches++;
      end
    endfunction

    function void check_result(logic [79:0] word);
      res_t got;
      res_t want;
      got = word[$bits(res_t)-1:0];
      if (pending_replies.size() == 0) begin
        $error("result transaction with no request outstanding: %h", word);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      compare_field("success", 32'(want.ok), 32'(got.ok));
      compare_field("table_full", 32'(want.full), 32'(got.full));
      compare_field("found_key", want.fkey, got.fkey);
      compare_field("found_value", want.fval, got.fval);
      compare_field("entry_count", 32'(want.count), 32'(got.count));
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // req_key[31:0], req_value[63:32], req_index[69:64]
  logic [2:0]  in_tuser;   // func[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // success[0], table_full[1], found_key[33:2],
                           // found_value[65:34], entry_count[72:66]

  kv_table_scoreboard sb;
  logic [KEY_W-1:0]   key_pool[96];
  bit                 idle_on;
  bit                 rx_hold_req;
  int unsigned        cycle_count;

  ordered_key_value_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver: ready for random stretches, short stalls while idling is on, and one long
  // hold-off on request so that the core backs up into its input.
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic [2:0] op, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] value, logic [IDX_W-1:0] index);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, index, value, key};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, key, value, index);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic wait_for_replies();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_func(load_mix_t mix);
    int unsigned cut[7];
    int unsigned r;
    logic [2:0]  ops[7];
    ops = '{FN_INSERT, FN_INS_UPD, FN_UPDATE, FN_ERASE, FN_GET_KEY, FN_GET_IDX, FN_CONTAINS};
    case (mix)
      LOAD_FILL:  cut = '{45, 65, 72, 77, 84, 92, 98};
      LOAD_DRAIN: cut = '{8, 14, 22, 72, 80, 88, 97};
      default:    cut = '{15, 30, 42, 57, 70, 83, 97};
    endcase
    r = $urandom_range(0, 99);
    for (int i = 0; i < 7; i++) begin
      if (r < cut[i]) return ops[i];
    end
    return FN_UNUSED;
  endfunction

  // Keys mostly come from a fixed pool so that inserts collide and lookups hit; requests
  // that need a present key usually take one straight from the shadow table.
  function automatic logic [KEY_W-1:0] pick_key(logic [2:0] op);
    int unsigned hit_pct;
    hit_pct = (op == FN_INSERT || op == FN_INS_UPD) ? 20 : 70;
    if (sb.fill > 0 && $urandom_range(0, 99) < hit_pct)
      return sb.shadow_keys[$urandom_range(0, sb.fill - 1)];
    if ($urandom_range(0, 19) == 0) return $urandom;
    return key_pool[$urandom_range(0, 95)];
  endfunction

  initial begin
    load_mix_t        schedule[SEGMENTS];
    logic [2:0]       op;
    logic [IDX_W-1:0] index;
    int unsigned      top;

    schedule = '{LOAD_FILL, LOAD_FILL, LOAD_MIXED, LOAD_DRAIN, LOAD_MIXED, LOAD_FILL,
                 LOAD_FILL, LOAD_FILL, LOAD_MIXED, LOAD_DRAIN, LOAD_DRAIN, LOAD_MIXED,
                 LOAD_FILL, LOAD_FILL, LOAD_MIXED, LOAD_DRAIN};
    sb = new();
    idle_on = 1'b1;
    rx_hold_req = 1'b0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 96; i++) key_pool[i] = $urandom;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= FN_INSERT;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation but insert-or-update on an empty table, then extreme keys and values,
    // duplicates, updates, reads past the end and erases at both ends.
    send_request(FN_GET_IDX, 32'h0, 32'h0, 6'd0);
    send_request(FN_ERASE, 32'h0, 32'h0, 6'd0);
    send_request(FN_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_request(FN_CONTAINS, 32'h0, 32'h0, 6'd0);
    send_request(FN_GET_KEY, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_request(FN_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    send_request(FN_INSERT, 32'h0, 32'hFFFF_FFFF, 6'd0);
    send_request(FN_INSERT, 32'hFFFF_FFFF, 32'h0, 6'd63);
    send_request(FN_INSERT, 32'h0, 32'h5555_5555, 6'd0);
    send_request(FN_INS_UPD, 32'h0, 32'h1234_5678, 6'd0);
    send_request(FN_INS_UPD, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 6'd21);
    send_request(FN_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd42);
    send_request(FN_GET_KEY, 32'h0, 32'hFFFF_FFFF, 6'd0);
    send_request(FN_GET_KEY, 32'hFFFF_FFFF, 32'h0, 6'd0);
    send_request(FN_GET_IDX, 32'h0, 32'h0, 6'd0);
    send_request(FN_GET_IDX, 32'h0, 32'h0, 6'd2);
    send_request(FN_GET_IDX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd3);
    send_request(FN_GET_IDX, 32'h0, 32'h0, 6'd63);
    send_request(FN_CONTAINS, 32'h0, 32'h0, 6'd0);
    send_request(FN_ERASE, 32'h0, 32'h0, 6'd0);
    send_request(FN_GET_IDX, 32'h0, 32'h0, 6'd0);
    send_request(FN_ERASE, 32'hA5A5_A5A5, 32'h0, 6'd0);
    send_request(FN_UNUSED, 32'h0, 32'h0, 6'd0);
    send_request(FN_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // Now and then the sender stops until every reply has come back.
      if (seg % 4 == 0) begin
        in_tvalid <= 1'b0;
        wait_for_replies();
      end
      idle_on = (seg < SEGMENTS - 2) && (seg != 6);
      if (seg == 2) rx_hold_req = 1'b1;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        op = pick_func(schedule[seg]);
        top = (sb.fill > 63) ? 63 : sb.fill;
        if ($urandom_range(0, 3) == 0) index = IDX_W'($urandom_range(0, 63));
        else index = IDX_W'($urandom_range(0, top));
        send_request(op, pick_key(op), random_word(), index);
      end
    end

    in_tvalid <= 1'b0;
    wait_for_replies();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
